// ===== sv/jzhs_pkg.sv =====
// ----------------------------------------------------------------------------
// jzhs_pkg
// Shared types, codes and helpers for the JPEG/ZIP header scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package jzhs_pkg;

    localparam int MAX_RESULTS = 3;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

    localparam int TDATA_OUT_W = 160;
    localparam int HEADER_LAST = 25;

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_RECORD  = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [2:0] VERD_SHORT     = 3'd0;
    localparam logic [2:0] VERD_NOT_JPEG  = 3'd1;
    localparam logic [2:0] VERD_NO_ZIP    = 3'd2;
    localparam logic [2:0] VERD_ZIP       = 3'd3;
    localparam logic [2:0] VERD_MALFORMED = 3'd4;

    localparam logic [7:0] MAGIC_FF = 8'hff;
    localparam logic [7:0] MAGIC_D8 = 8'hd8;
    localparam logic [7:0] SIG_0    = 8'h50;
    localparam logic [7:0] SIG_1    = 8'h4b;
    localparam logic [7:0] SIG_2    = 8'h03;
    localparam logic [7:0] SIG_3    = 8'h04;

    localparam logic [15:0] METHOD_STORED  = 16'd0;
    localparam logic [15:0] METHOD_DEFLATE = 16'd8;

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_NOTJPEG,
        PH_SEARCH,
        PH_HEADER,
        PH_NAME,
        PH_MALFORMED
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_byte;
        logic        name_last;
        logic [15:0] method;
        logic [31:0] compressed_size;
        logic [31:0] uncompressed_size;
        logic [15:0] name_length;
        logic [31:0] header_offset;
        logic [15:0] entry_number;
        logic [2:0]  verdict;
        logic        last_of_run;
    } t_row;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = SIG_0;
            2'd1: b = SIG_1;
            2'd2: b = SIG_2;
            2'd3: b = SIG_3;
            default: b = SIG_0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/jpeg_zip_header_scanner_core.sv =====
// ----------------------------------------------------------------------------
// jpeg_zip_header_scanner_core
// JPEG file scanner that finds appended ZIP local file headers.
// ----------------------------------------------------------------------------
// Takes one file byte per clock while the queue has room. Each accepted byte
// is held in an input register while the scanner state updates, and its
// results (a filename byte, an entry record and/or the final verdict, at
// most three) go into a four-entry result queue that sends one result per
// clock while the output is ready. The input takes a new byte every clock as
// long as the queue holds at most one pending result; a byte that yields
// several results therefore stalls the input until the queue drains.
`default_nettype none

module jpeg_zip_header_scanner_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire logic         s_axis_tlast,   // last_byte
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [7:0] name_byte, [8] name_last, [24:9] method, [56:25] compressed_size,
    // [88:57] uncompressed_size, [104:89] name_length, [136:105] header_offset,
    // [152:137] entry_number, [155:153] verdict, [159:156] zero
    output logic [jzhs_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    output logic [1:0]        m_axis_tuser,   // [1:0] kind
    output logic              m_axis_tlast    // last_of_run
);
    import jzhs_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       space;
    logic       go;
    t_row [MAX_RESULTS-1:0] rows;
    logic [RCNT_W-1:0]      row_count;
    t_row                   head;

    assign go            = r_in_valid && space;
    assign s_axis_tready = !r_in_valid || space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    jzhs_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_rows      (rows),
        .o_count     (row_count)
    );

    jzhs_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (go),
        .i_rows  (rows),
        .i_count (row_count),
        .o_space (space),
        .o_valid (m_axis_tvalid),
        .o_row   (head),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last_of_run;
    assign m_axis_tdata = {4'd0, head.verdict, head.entry_number, head.header_offset,
                           head.name_length, head.uncompressed_size,
                           head.compressed_size, head.method, head.name_last,
                           head.name_byte};

endmodule

`default_nettype wire

// ===== sv/jzhs_step.sv =====
// ----------------------------------------------------------------------------
// jzhs_step
// Scanner state and per-byte update; emits up to three result rows per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jzhs_step (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_go,
    input  wire logic [7:0]                            i_data_byte,
    input  wire logic                                  i_last_byte,
    output jzhs_pkg::t_row [jzhs_pkg::MAX_RESULTS-1:0] o_rows,
    output logic [jzhs_pkg::RCNT_W-1:0]                o_count
);
    import jzhs_pkg::*;

    t_phase      r_phase,     n_phase;
    logic [31:0] r_pos,       n_pos;
    logic [2:0]  r_sig_cnt,   n_sig_cnt;
    logic [4:0]  r_hdr_cnt,   n_hdr_cnt;
    logic [15:0] r_method,    n_method;
    logic [31:0] r_csize,     n_csize;
    logic [31:0] r_usize,     n_usize;
    logic [15:0] r_nlen,      n_nlen;
    logic [15:0] r_nleft,     n_nleft;
    logic [31:0] r_cur_off,   n_cur_off;
    logic [31:0] r_first_off, n_first_off;
    logic        r_zip_seen,  n_zip_seen;
    logic [15:0] r_acc_cnt,   n_acc_cnt;

    always_comb begin
        logic       do_finish;
        logic [7:0] b;
        logic [RCNT_W-1:0] idx;
        logic [2:0] verd;

        b         = i_data_byte;
        do_finish = 1'b0;
        idx       = '0;
        verd      = VERD_SHORT;
        o_rows    = '0;

        n_phase     = r_phase;
        n_pos       = r_pos;
        n_sig_cnt   = r_sig_cnt;
        n_hdr_cnt   = r_hdr_cnt;
        n_method    = r_method;
        n_csize     = r_csize;
        n_usize     = r_usize;
        n_nlen      = r_nlen;
        n_nleft     = r_nleft;
        n_cur_off   = r_cur_off;
        n_first_off = r_first_off;
        n_zip_seen  = r_zip_seen;
        n_acc_cnt   = r_acc_cnt;

        unique case (r_phase)
            PH_MAGIC: begin
                if (b != ((r_pos == 32'd1) ? MAGIC_D8 : MAGIC_FF)) begin
                    n_phase = PH_NOTJPEG;
                end else if (r_pos >= 32'd2) begin
                    n_phase = PH_SEARCH;
                end
            end
            PH_SEARCH: begin
                if (b == sig_byte(r_sig_cnt[1:0])) begin
                    n_sig_cnt = r_sig_cnt + 3'd1;
                end else begin
                    n_sig_cnt = (b == SIG_0) ? 3'd1 : 3'd0;
                end
                if (n_sig_cnt >= 3'd4) begin
                    n_sig_cnt = '0;
                    n_cur_off = (r_pos >= 32'd3) ? r_pos - 32'd3 : 32'd0;
                    if (!r_zip_seen) begin
                        n_first_off = n_cur_off;
                        n_zip_seen  = 1'b1;
                    end
                    n_hdr_cnt = '0;
                    n_method  = '0;
                    n_csize   = '0;
                    n_usize   = '0;
                    n_nlen    = '0;
                    n_phase   = PH_HEADER;
                end
            end
            PH_HEADER: begin
                unique case (r_hdr_cnt)
                    5'd4:    n_method[7:0]   = b;
                    5'd5:    n_method[15:8]  = b;
                    5'd14:   n_csize[7:0]    = b;
                    5'd15:   n_csize[15:8]   = b;
                    5'd16:   n_csize[23:16]  = b;
                    5'd17:   n_csize[31:24]  = b;
                    5'd18:   n_usize[7:0]    = b;
                    5'd19:   n_usize[15:8]   = b;
                    5'd20:   n_usize[23:16]  = b;
                    5'd21:   n_usize[31:24]  = b;
                    5'd22:   n_nlen[7:0]     = b;
                    5'd23:   n_nlen[15:8]    = b;
                    default: ;
                endcase
                n_hdr_cnt = r_hdr_cnt + 5'd1;
                if (r_hdr_cnt >= 5'(HEADER_LAST)) begin
                    n_hdr_cnt = '0;
                    n_nleft   = n_nlen;
                    if (n_nlen == 16'd0) begin
                        do_finish = 1'b1;
                    end else begin
                        n_phase = PH_NAME;
                    end
                end
            end
            PH_NAME: begin
                o_rows[idx].kind      = KIND_NAME;
                o_rows[idx].name_byte = b;
                o_rows[idx].name_last = (r_nleft == 16'd1);
                idx = idx + 1'b1;
                if (r_nleft != 16'd0) begin
                    n_nleft = r_nleft - 16'd1;
                end
                if (n_nleft == 16'd0) begin
                    do_finish = 1'b1;
                end
            end
            PH_NOTJPEG, PH_MALFORMED: ;
            default: ;
        endcase

        if (do_finish) begin
            if (n_method == METHOD_STORED || n_method == METHOD_DEFLATE) begin
                o_rows[idx].kind              = KIND_RECORD;
                o_rows[idx].method            = n_method;
                o_rows[idx].compressed_size   = n_csize;
                o_rows[idx].uncompressed_size = n_usize;
                o_rows[idx].name_length       = n_nlen;
                o_rows[idx].header_offset     = n_cur_off;
                o_rows[idx].entry_number      = n_acc_cnt;
                idx = idx + 1'b1;
                if (n_acc_cnt != 16'hffff) begin
                    n_acc_cnt = n_acc_cnt + 16'd1;
                end
                n_sig_cnt = '0;
                n_phase   = PH_SEARCH;
            end else begin
                n_phase = PH_MALFORMED;
            end
        end

        if (r_pos != 32'hffff_ffff) begin
            n_pos = r_pos + 32'd1;
        end

        if (i_last_byte) begin
            if (r_pos < 32'd2) begin
                verd = VERD_SHORT;
            end else if (n_phase == PH_NOTJPEG || n_phase == PH_MAGIC) begin
                verd = VERD_NOT_JPEG;
            end else if (n_phase == PH_SEARCH) begin
                verd = n_zip_seen ? VERD_ZIP : VERD_NO_ZIP;
            end else begin
                verd = VERD_MALFORMED;
            end
            o_rows[idx].kind          = KIND_VERDICT;
            o_rows[idx].header_offset = n_first_off;
            o_rows[idx].entry_number  = n_acc_cnt;
            o_rows[idx].verdict       = verd;
            idx = idx + 1'b1;

            n_phase     = PH_MAGIC;
            n_pos       = '0;
            n_sig_cnt   = '0;
            n_hdr_cnt   = '0;
            n_method    = '0;
            n_csize     = '0;
            n_usize     = '0;
            n_nlen      = '0;
            n_nleft     = '0;
            n_cur_off   = '0;
            n_first_off = '0;
            n_zip_seen  = 1'b0;
            n_acc_cnt   = '0;
        end

        if (idx != '0) begin
            o_rows[idx - 1'b1].last_of_run = 1'b1;
        end
        o_count = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_pos       <= '0;
            r_sig_cnt   <= '0;
            r_hdr_cnt   <= '0;
            r_method    <= '0;
            r_csize     <= '0;
            r_usize     <= '0;
            r_nlen      <= '0;
            r_nleft     <= '0;
            r_cur_off   <= '0;
            r_first_off <= '0;
            r_zip_seen  <= 1'b0;
            r_acc_cnt   <= '0;
        end else if (i_go) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_sig_cnt   <= n_sig_cnt;
            r_hdr_cnt   <= n_hdr_cnt;
            r_method    <= n_method;
            r_csize     <= n_csize;
            r_usize     <= n_usize;
            r_nlen      <= n_nlen;
            r_nleft     <= n_nleft;
            r_cur_off   <= n_cur_off;
            r_first_off <= n_first_off;
            r_zip_seen  <= n_zip_seen;
            r_acc_cnt   <= n_acc_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== sv/jzhs_result_queue.sv =====
// ----------------------------------------------------------------------------
// jzhs_result_queue
// Small result queue: takes up to three rows per cycle when it has space, sends one per cycle when ready.
// ----------------------------------------------------------------------------
`default_nettype none

module jzhs_result_queue (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_push,
    input  wire jzhs_pkg::t_row [jzhs_pkg::MAX_RESULTS-1:0] i_rows,
    input  wire logic [jzhs_pkg::RCNT_W-1:0]           i_count,
    output logic                                       o_space,
    output logic                                       o_valid,
    output jzhs_pkg::t_row                             o_row,
    input  wire logic                                  i_ready
);
    import jzhs_pkg::*;

    t_row              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic [QCNT_W-1:0] push_n;
    logic              pop;

    assign o_valid = (r_count != '0);
    assign o_row   = r_mem[r_rd_ptr];
    assign o_space = (r_count <= QCNT_W'(QDEPTH - MAX_RESULTS));
    assign pop     = o_valid && i_ready;
    assign push_n  = i_push ? QCNT_W'(i_count) : '0;

    always_comb begin
        n_wr_ptr = r_wr_ptr + QPTR_W'(push_n);
        n_rd_ptr = r_rd_ptr + QPTR_W'(pop);
        n_count  = r_count + push_n - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                if (RCNT_W'(k) < i_count) begin
                    r_mem[r_wr_ptr + QPTR_W'(k)] <= i_rows[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== sv/jzhs_checker.sv =====
// ----------------------------------------------------------------------------
// jzhs_checker
// Port-level checks for the JPEG/ZIP header scanner.
// ----------------------------------------------------------------------------
`default_nettype none

module jzhs_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [jzhs_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    input wire logic [1:0]   m_axis_tuser,
    input wire logic         m_axis_tlast
);
    import jzhs_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not empty and ready right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_VERDICT |->
            m_axis_tlast && m_axis_tdata[155:153] <= VERD_MALFORMED)
        else $error("verdict row malformed");

    a_record_method: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_RECORD |->
            m_axis_tdata[24:9] == METHOD_STORED || m_axis_tdata[24:9] == METHOD_DEFLATE)
        else $error("record with bad method");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tuser == KIND_NAME || m_axis_tuser == KIND_RECORD ||
            m_axis_tuser == KIND_VERDICT)
        else $error("bad result kind");

endmodule

bind jpeg_zip_header_scanner_core jzhs_checker u_jzhs_checker (.*);

`default_nettype wire

// ===== verif/jpeg_zip_header_scanner_core_tb.sv =====
// ----------------------------------------------------------------------------
// jpeg_zip_header_scanner_core_tb
// Self-checking bench for the JPEG/ZIP local header scanner.
// ----------------------------------------------------------------------------
// Byte streams (short files, non-JPEG data, JPEG files with and without
// appended ZIP local headers, bad and truncated headers, random files) go in
// on the input stream. An in-bench scanner model predicts every filename
// byte, entry record and verdict, and a monitor checks each output request
// against the oldest prediction. Both sides idle at random; one test holds
// the output off for a long stretch so the block backs up and stalls input.
// ----------------------------------------------------------------------------
module jpeg_zip_header_scanner_core_tb;
    import jzhs_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int RANDOM_BYTES = 40;
    localparam logic [31:0] ZIP_SIG = {SIG_3, SIG_2, SIG_1, SIG_0};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;   // [7:0] data_byte
    logic                   s_axis_tlast;   // last_byte
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [7:0] name_byte, [8] name_last, [24:9] method, [56:25] compressed_size,
    // [88:57] uncompressed_size, [104:89] name_length, [136:105] header_offset,
    // [152:137] entry_number, [155:153] verdict, [159:156] zero
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;   // [1:0] kind
    logic                   m_axis_tlast;   // last_of_run

    jpeg_zip_header_scanner_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // scanner model state
    t_phase      scan_phase;
    logic [31:0] scan_pos;
    logic [2:0]  sig_cnt;
    logic [4:0]  hdr_cnt;
    logic [15:0] h_method;
    logic [31:0] h_csize;
    logic [31:0] h_usize;
    logic [15:0] h_nlen;
    logic [15:0] name_left;
    logic [31:0] cur_off;
    logic [31:0] first_off;
    logic        zip_seen;
    logic [15:0] n_accepted;

    t_row        step_rows[$];
    t_row        rows_due[$];
    logic [7:0]  file_q[$];

    int unsigned bytes_accepted = 0;
    int unsigned errors = 0;
    int unsigned cycle_cnt = 0;
    int          rx_hold_req = 0;
    bit          idle_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic clear_scan_state();
        scan_phase = PH_MAGIC;
        scan_pos   = '0;
        sig_cnt    = '0;
        hdr_cnt    = '0;
        h_method   = '0;
        h_csize    = '0;
        h_usize    = '0;
        h_nlen     = '0;
        name_left  = '0;
        cur_off    = '0;
        first_off  = '0;
        zip_seen   = 1'b0;
        n_accepted = '0;
    endtask

    task automatic close_entry();
        t_row r;
        if (h_method == METHOD_STORED || h_method == METHOD_DEFLATE) begin
            r = '0;
            r.kind              = KIND_RECORD;
            r.method            = h_method;
            r.compressed_size   = h_csize;
            r.uncompressed_size = h_usize;
            r.name_length       = h_nlen;
            r.header_offset     = cur_off;
            r.entry_number      = n_accepted;
            step_rows.push_back(r);
            if (n_accepted != 16'hffff)
                n_accepted = n_accepted + 16'd1;
            sig_cnt    = '0;
            scan_phase = PH_SEARCH;
        end else begin
            scan_phase = PH_MALFORMED;
        end
    endtask

    task automatic model_scan_byte(input logic [7:0] b, input logic is_last);
        t_row        r;
        logic [31:0] pos;
        logic [4:0]  idx;
        logic [2:0]  verd;
        int          k;
        pos = scan_pos;
        step_rows.delete();
        case (scan_phase)
            PH_MAGIC: begin
                if (b != ((pos == 32'd1) ? MAGIC_D8 : MAGIC_FF))
                    scan_phase = PH_NOTJPEG;
                else if (pos >= 32'd2)
                    scan_phase = PH_SEARCH;
            end
            PH_SEARCH: begin
                if (b == ZIP_SIG[8*sig_cnt[1:0] +: 8])
                    sig_cnt = sig_cnt + 3'd1;
                else
                    sig_cnt = (b == SIG_0) ? 3'd1 : 3'd0;
                if (sig_cnt >= 3'd4) begin
                    sig_cnt = '0;
                    cur_off = (pos >= 32'd3) ? pos - 32'd3 : 32'd0;
                    if (!zip_seen) begin
                        first_off = cur_off;
                        zip_seen  = 1'b1;
                    end
                    hdr_cnt    = '0;
                    h_method   = '0;
                    h_csize    = '0;
                    h_usize    = '0;
                    h_nlen     = '0;
                    scan_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                idx = hdr_cnt;
                k = idx;
                if (k == 4)
                    h_method[7:0] = b;
                else if (k == 5)
                    h_method[15:8] = b;
                else if (k >= 14 && k <= 17)
                    h_csize[8*(k-14) +: 8] = b;
                else if (k >= 18 && k <= 21)
                    h_usize[8*(k-18) +: 8] = b;
                else if (k == 22)
                    h_nlen[7:0] = b;
                else if (k == 23)
                    h_nlen[15:8] = b;
                hdr_cnt = idx + 5'd1;
                if (k == HEADER_LAST) begin
                    hdr_cnt   = '0;
                    name_left = h_nlen;
                    if (name_left == 16'd0)
                        close_entry();
                    else
                        scan_phase = PH_NAME;
                end
            end
            PH_NAME: begin
                r = '0;
                r.kind      = KIND_NAME;
                r.name_byte = b;
                r.name_last = (name_left == 16'd1);
                step_rows.push_back(r);
                if (name_left != 16'd0)
                    name_left = name_left - 16'd1;
                if (name_left == 16'd0)
                    close_entry();
            end
            default: ;
        endcase

        if (scan_pos != 32'hffff_ffff)
            scan_pos = scan_pos + 32'd1;

        if (is_last) begin
            if (pos < 32'd2)
                verd = VERD_SHORT;
            else if (scan_phase == PH_NOTJPEG || scan_phase == PH_MAGIC)
                verd = VERD_NOT_JPEG;
            else if (scan_phase == PH_SEARCH)
                verd = zip_seen ? VERD_ZIP : VERD_NO_ZIP;
            else
                verd = VERD_MALFORMED;
            r = '0;
            r.kind          = KIND_VERDICT;
            r.header_offset = first_off;
            r.entry_number  = n_accepted;
            r.verdict       = verd;
            step_rows.push_back(r);
            clear_scan_state();
        end

        if (step_rows.size() > 0)
            step_rows[step_rows.size()-1].last_of_run = 1'b1;
        foreach (step_rows[i])
            rows_due.push_back(step_rows[i]);
    endtask

    function automatic string row_text(input t_row r);
        return $sformatf({"kind=%0d byte=%02h nlast=%0d meth=%04h csz=%08h usz=%08h ",
                          "nlen=%0d off=%0d ent=%0d verd=%0d tlast=%0d"},
                         r.kind, r.name_byte, r.name_last, r.method, r.compressed_size,
                         r.uncompressed_size, r.name_length, r.header_offset,
                         r.entry_number, r.verdict, r.last_of_run);
    endfunction

    // output monitor
    always @(posedge i_clk) begin
        t_row act;
        t_row exp_row;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act.kind              = m_axis_tuser;
            act.name_byte         = m_axis_tdata[7:0];
            act.name_last         = m_axis_tdata[8];
            act.method            = m_axis_tdata[24:9];
            act.compressed_size   = m_axis_tdata[56:25];
            act.uncompressed_size = m_axis_tdata[88:57];
            act.name_length       = m_axis_tdata[104:89];
            act.header_offset     = m_axis_tdata[136:105];
            act.entry_number      = m_axis_tdata[152:137];
            act.verdict           = m_axis_tdata[155:153];
            act.last_of_run       = m_axis_tlast;
            if (rows_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %s", row_text(act));
            end else begin
                exp_row = rows_due.pop_front();
                if (act !== exp_row) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch at cycle %0d", cycle_cnt);
                        $display("  expected %s", row_text(exp_row));
                        $display("  actual   %s", row_text(act));
                    end
                end
            end
        end
    end

    // output sink: random stalls, plus long hold-offs on request
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req > 0) begin
                stall_left  = rx_hold_req;
                rx_hold_req = 0;
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 99) < 20) begin
                m_axis_tready <= 1'b0;
                r = $urandom_range(0, 99);
                if (r >= 95)
                    stall_left = $urandom_range(10, 30);
                else if (r >= 70)
                    stall_left = $urandom_range(1, 3);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        int r;
        gap = 0;
        if (idle_on) begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(8, 30);
            else if (r >= 70)
                gap = $urandom_range(1, 3);
        end
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        model_scan_byte(b, is_last);
        bytes_accepted++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
    endtask

    task automatic add_magic();
        file_q.push_back(MAGIC_FF);
        file_q.push_back(MAGIC_D8);
        file_q.push_back(MAGIC_FF);
    endtask

    // random bytes, salted with partial signatures to exercise match restart
    task automatic add_filler(input int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                file_q.push_back(SIG_0);
            end else if (r < 14) begin
                file_q.push_back(SIG_0);
                file_q.push_back(SIG_1);
            end else if (r < 18) begin
                file_q.push_back(SIG_0);
                file_q.push_back(SIG_1);
                file_q.push_back(SIG_2);
            end else begin
                file_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic add_entry(input logic [15:0] meth, input logic [31:0] csz,
                             input logic [31:0] usz, input logic [15:0] nlen,
                             input int name_cnt);
        file_q.push_back(SIG_0);
        file_q.push_back(SIG_1);
        file_q.push_back(SIG_2);
        file_q.push_back(SIG_3);
        for (int i = 0; i <= HEADER_LAST; i++) begin
            if (i == 4)
                file_q.push_back(meth[7:0]);
            else if (i == 5)
                file_q.push_back(meth[15:8]);
            else if (i >= 14 && i <= 17)
                file_q.push_back(csz[8*(i-14) +: 8]);
            else if (i >= 18 && i <= 21)
                file_q.push_back(usz[8*(i-18) +: 8]);
            else if (i == 22)
                file_q.push_back(nlen[7:0]);
            else if (i == 23)
                file_q.push_back(nlen[15:8]);
            else
                file_q.push_back(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < name_cnt; i++)
            file_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic test_short_files();
        file_q = '{MAGIC_FF};
        send_file();
        file_q = '{8'h00};
        send_file();
        file_q = '{MAGIC_FF, MAGIC_D8};
        send_file();
        file_q = '{8'h12, MAGIC_D8};
        send_file();
        file_q = '{MAGIC_FF, MAGIC_D8, MAGIC_FF};
        send_file();
    endtask

    task automatic test_not_jpeg();
        file_q = '{MAGIC_FF, MAGIC_D8, 8'h00, SIG_0, SIG_1, SIG_2, SIG_3, 8'h7f};
        send_file();
        file_q = '{MAGIC_FF, 8'hff, MAGIC_FF};
        send_file();
    endtask

    task automatic test_good_entries();
        // restart on a repeated first signature byte, then two entries,
        // the second completing its header on the final byte
        file_q.delete();
        add_magic();
        file_q.push_back(SIG_0);
        add_entry(METHOD_DEFLATE, 32'hffff_ffff, 32'h0, 16'd2, 2);
        file_q.push_back(8'haa);
        add_entry(METHOD_STORED, 32'h1234_5678, 32'h9abc_def0, 16'd0, 0);
        send_file();
        // name ends on the final byte: name byte, record and verdict together
        file_q.delete();
        add_magic();
        add_entry(METHOD_STORED, 32'h0, 32'hffff_ffff, 16'd1, 1);
        send_file();
    endtask

    task automatic test_bad_headers();
        // good entry, then a bad method; later signatures are ignored
        file_q.delete();
        add_magic();
        add_entry(METHOD_DEFLATE, 32'h10, 32'h20, 16'd0, 0);
        add_entry(16'hffff, 32'h0, 32'h0, 16'd1, 1);
        add_entry(METHOD_STORED, 32'h0, 32'h0, 16'd0, 0);
        file_q.push_back(8'h00);
        send_file();
        // truncated header
        file_q.delete();
        add_magic();
        add_entry(METHOD_STORED, 32'h0, 32'h0, 16'd0, 0);
        repeat (16) void'(file_q.pop_back());
        send_file();
        // truncated filename
        file_q.delete();
        add_magic();
        add_entry(METHOD_DEFLATE, 32'h5, 32'h6, 16'd3, 1);
        send_file();
    endtask

    task automatic test_output_backpressure();
        idle_on = 1'b0;
        rx_hold_req = 80;
        file_q.delete();
        add_magic();
        add_entry(METHOD_DEFLATE, $urandom, $urandom, 16'd12, 12);
        add_entry(METHOD_STORED, $urandom, $urandom, 16'd3, 3);
        send_file();
        idle_on = 1'b1;
    endtask

    task automatic build_random_file();
        int          sel;
        int          n_ent;
        int          nlen;
        int          cut;
        int          r;
        logic [15:0] meth;
        file_q.delete();
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            add_magic();
            add_filler($urandom_range(0, 6));
            n_ent = $urandom_range(1, 3);
            for (int i = 0; i < n_ent; i++) begin
                r = $urandom_range(0, 99);
                if (r < 40)
                    meth = METHOD_STORED;
                else if (r < 80)
                    meth = METHOD_DEFLATE;
                else
                    meth = 16'($urandom_range(0, 65535));
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    add_entry(meth, $urandom, $urandom, 16'($urandom_range(0, 65535)), 2);
                end else begin
                    nlen = (r < 25) ? 0 : $urandom_range(1, 5);
                    add_entry(meth, $urandom, $urandom, 16'(nlen), nlen);
                end
                add_filler($urandom_range(0, 4));
            end
            if ($urandom_range(0, 4) == 0) begin
                cut = $urandom_range(1, file_q.size());
                while (file_q.size() > cut)
                    void'(file_q.pop_back());
            end
        end else if (sel < 85) begin
            if ($urandom_range(0, 1) == 1)
                add_magic();
            repeat ($urandom_range(1, 10))
                file_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            add_magic();
            file_q[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
            add_filler($urandom_range(1, 8));
        end
    endtask

    task automatic test_random_files();
        int unsigned start;
        start = bytes_accepted;
        while (bytes_accepted - start < RANDOM_BYTES) begin
            idle_on = ($urandom_range(0, 3) != 0);
            build_random_file();
            send_file();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        int waited;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        clear_scan_state();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_files();
        test_not_jpeg();
        test_good_entries();
        test_bad_headers();
        test_output_backpressure();
        test_random_files();

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        waited = 0;
        while (rows_due.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (rows_due.size() > 0) begin
            errors += rows_due.size();
            $display("%0d expected results never arrived", rows_due.size());
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
